>>> rtl/core/nal_config_record_to_annexb_top_assert.svh
// Assertion macros for the configuration record to Annex-B converter.
`ifndef NAL_CONFIG_RECORD_TO_ANNEXB_TOP_ASSERT_SVH
`define NAL_CONFIG_RECORD_TO_ANNEXB_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Combinational property, checked at every clock edge outside reset.
`define NCR2AB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define NCR2AB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define NCR2AB_ASSERT(lbl, prop, msg)
`define NCR2AB_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

>>> rtl/core/ncr2ab_pkg.sv
// Types and constants of the configuration record to Annex-B converter.
package ncr2ab_pkg;

  typedef struct packed {
    logic [7:0] record_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       byte_present;
    logic       run_end;
    logic [2:0] status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_TRUNCATED   = 3'd2,
    ST_ZERO_LEN    = 3'd3,
    ST_NOTHING     = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_PPS_COUNT,
    PH_ARR_HDR,
    PH_DONE
  } phase_e;

  // What the parser produces for one accepted record byte.
  typedef struct packed {
    logic       item;        // at least one output transaction follows
    logic       start_code;  // 00 00 00 01 precedes the payload byte
    logic       byte_present;
    logic [7:0] data;
    logic       run_end;
    status_e    status;
  } res_t;

  localparam logic [7:0] VERSION_BYTE   = 8'h01;
  localparam logic [4:0] AVC_COUNT_IDX  = 5'd5;
  localparam logic [4:0] HEVC_COUNT_IDX = 5'd22;
  localparam logic [4:0] SPS_COUNT_MASK = 5'h1f;
  localparam logic [2:0] START_CODE_LEN = 3'd4;

endpackage

>>> rtl/core/ncr2ab_parser.sv
// Record parser: walks the header and length-prefixed NAL lists one byte a cycle while take_i is high.
module ncr2ab_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fmt_i,
  input  logic              take_i,
  input  logic [7:0]        byte_i,
  input  logic              final_i,
  output ncr2ab_pkg::res_t  res_o
);
  import ncr2ab_pkg::*;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] arrays;
    logic       clr_hidx;
  } end_list_t;

  phase_e      ph_q, ph_d;
  logic [4:0]  hidx_q, hidx_d;
  logic [7:0]  arr_q, arr_d;
  logic [15:0] nals_q, nals_d;
  logic [15:0] nbl_q, nbl_d;
  logic [7:0]  lhi_q, lhi_d;
  logic        pend_q, pend_d;
  status_e     err_q, err_d;
  logic        emit_q, emit_d;

  function automatic end_list_t end_list(input logic fmt, input logic [7:0] arrays);
    end_list_t r;
    r.phase    = PH_DONE;
    r.arrays   = arrays;
    r.clr_hidx = 1'b0;
    if (!fmt) begin
      if (arrays != 8'd0) begin
        r.arrays = 8'd0;
        r.phase  = PH_PPS_COUNT;
      end
    end else begin
      if (arrays != 8'd0) begin
        r.arrays = arrays - 8'd1;
      end
      if (r.arrays != 8'd0) begin
        r.phase    = PH_ARR_HDR;
        r.clr_hidx = 1'b1;
      end
    end
    return r;
  endfunction

  always_comb begin
    logic [15:0] cnt;
    logic        start_list;
    logic        finish;
    end_list_t   el;
    cnt        = '0;
    start_list = 1'b0;
    finish     = 1'b0;
    el         = '0;
    ph_d   = ph_q;
    hidx_d = hidx_q;
    arr_d  = arr_q;
    nals_d = nals_q;
    nbl_d  = nbl_q;
    lhi_d  = lhi_q;
    pend_d = pend_q;
    err_d  = err_q;
    emit_d = emit_q;
    res_o  = '0;
    res_o.data = byte_i;

    if (err_q == ST_OK) begin
      case (ph_q)
        PH_HDR: begin
          hidx_d = hidx_q + 5'd1;
          if (hidx_q == 5'd0 && byte_i != VERSION_BYTE) begin
            err_d = ST_BAD_VERSION;
          end else if (!fmt_i) begin
            if (hidx_q == AVC_COUNT_IDX) begin
              arr_d      = 8'd1;
              cnt        = {11'd0, byte_i[4:0] & SPS_COUNT_MASK};
              start_list = 1'b1;
            end
          end else if (hidx_q == HEVC_COUNT_IDX) begin
            arr_d = byte_i;
            if (byte_i == 8'd0) begin
              ph_d = PH_DONE;
            end else begin
              ph_d   = PH_ARR_HDR;
              hidx_d = 5'd0;
            end
          end
        end
        PH_ARR_HDR: begin
          if (hidx_q == 5'd0) begin
            hidx_d = 5'd1;
          end else if (hidx_q == 5'd1) begin
            lhi_d  = byte_i;
            hidx_d = 5'd2;
          end else begin
            hidx_d     = 5'd0;
            cnt        = {lhi_q, byte_i};
            start_list = 1'b1;
          end
        end
        PH_PPS_COUNT: begin
          arr_d      = 8'd0;
          cnt        = {8'd0, byte_i};
          start_list = 1'b1;
        end
        PH_LEN_HI: begin
          lhi_d = byte_i;
          ph_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          nbl_d = {lhi_q, byte_i};
          if ({lhi_q, byte_i} == 16'd0) begin
            err_d = ST_ZERO_LEN;
          end else begin
            pend_d = 1'b1;
            ph_d   = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (pend_q) begin
            res_o.start_code = 1'b1;
            pend_d = 1'b0;
            emit_d = 1'b1;
          end
          res_o.byte_present = 1'b1;
          nbl_d = nbl_q - 16'd1;
          if (nbl_q == 16'd1) begin
            nals_d = nals_q - 16'd1;
            if (nals_q == 16'd1) begin
              finish = 1'b1;
            end else begin
              ph_d = PH_LEN_HI;
            end
          end
        end
        default: begin
        end
      endcase

      if (start_list) begin
        nals_d = cnt;
        if (cnt == 16'd0) begin
          finish = 1'b1;
        end else begin
          ph_d = PH_LEN_HI;
        end
      end
      if (finish) begin
        el    = end_list(fmt_i, arr_d);
        ph_d  = el.phase;
        arr_d = el.arrays;
        if (el.clr_hidx) begin
          hidx_d = 5'd0;
        end
      end
    end

    if (final_i) begin
      res_o.run_end = 1'b1;
      if (err_d != ST_OK) begin
        res_o.status = err_d;
      end else if (ph_d != PH_DONE) begin
        res_o.status = ST_TRUNCATED;
      end else if (!emit_d) begin
        res_o.status = ST_NOTHING;
      end else begin
        res_o.status = ST_OK;
      end
      // next byte opens a new record
      ph_d   = PH_HDR;
      hidx_d = '0;
      arr_d  = '0;
      nals_d = '0;
      nbl_d  = '0;
      lhi_d  = '0;
      pend_d = 1'b0;
      err_d  = ST_OK;
      emit_d = 1'b0;
    end
    res_o.item = res_o.byte_present | final_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_HDR;
      hidx_q <= '0;
      arr_q  <= '0;
      nals_q <= '0;
      nbl_q  <= '0;
      lhi_q  <= '0;
      pend_q <= 1'b0;
      err_q  <= ST_OK;
      emit_q <= 1'b0;
    end else if (take_i) begin
      ph_q   <= ph_d;
      hidx_q <= hidx_d;
      arr_q  <= arr_d;
      nals_q <= nals_d;
      nbl_q  <= nbl_d;
      lhi_q  <= lhi_d;
      pend_q <= pend_d;
      err_q  <= err_d;
      emit_q <= emit_d;
    end
  end

endmodule

>>> rtl/core/nal_config_record_to_annexb_top.sv
// Top level: configuration register, record parser and output transaction register.
//
// Converts an H.264 or HEVC decoder configuration record, fed one byte per
// input transaction, into Annex-B: each parameter set comes out as 00 00 00 01
// followed by its bytes, one byte per output transaction. A record byte is
// taken every cycle while output keeps up; the payload byte that opens a NAL
// produces five output transactions, so input stalls as the start code drains
// from the single output register, one transaction per cycle unless out_stall.
// The last output transaction of the final byte carries run_end and the status
// (with byte_present low if that byte emitted nothing). cfg_data_i selects HEVC
// when 1; the user must write it between records; the block does not enforce it.
module nal_config_record_to_annexb_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data_i,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ncr2ab_pkg::in_item_t  in_data_i,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ncr2ab_pkg::out_item_t out_data_o
);
  import ncr2ab_pkg::*;

  logic       fmt_q;
  logic [2:0] sc_left_q, sc_left_d;
  logic       pay_valid_q, pay_valid_d;
  logic       pay_present_q;
  logic [7:0] pay_byte_q;
  logic       run_end_q;
  status_e    status_q;
  logic       busy;
  logic       last_out;
  logic       take;
  res_t       res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      fmt_q <= cfg_data_i;
    end
  end

  assign busy     = (sc_left_q != 3'd0) || pay_valid_q;
  assign last_out = (sc_left_q == 3'd0) && !out_stall;
  assign in_stall = busy && !last_out;
  assign take     = in_valid && !in_stall;

  ncr2ab_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fmt_i   (fmt_q),
    .take_i  (take),
    .byte_i  (in_data_i.record_byte),
    .final_i (in_data_i.final_byte),
    .res_o   (res)
  );

  always_comb begin
    sc_left_d   = sc_left_q;
    pay_valid_d = pay_valid_q;
    if (out_valid && !out_stall) begin
      if (sc_left_q != 3'd0) begin
        sc_left_d = sc_left_q - 3'd1;
      end else begin
        pay_valid_d = 1'b0;
      end
    end
    if (take && res.item) begin
      sc_left_d   = res.start_code ? START_CODE_LEN : 3'd0;
      pay_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_left_q   <= '0;
      pay_valid_q <= 1'b0;
    end else begin
      sc_left_q   <= sc_left_d;
      pay_valid_q <= pay_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && res.item) begin
      pay_present_q <= res.byte_present;
      pay_byte_q    <= res.data;
      run_end_q     <= res.run_end;
      status_q      <= res.status;
    end
  end

  assign out_valid = busy;

  always_comb begin
    out_data_o = '0;
    if (sc_left_q != 3'd0) begin
      out_data_o.stream_byte  = (sc_left_q == 3'd1) ? 8'h01 : 8'h00;
      out_data_o.byte_present = 1'b1;
    end else if (pay_valid_q) begin
      out_data_o.stream_byte  = pay_present_q ? pay_byte_q : 8'h00;
      out_data_o.byte_present = pay_present_q;
      out_data_o.run_end      = run_end_q;
      out_data_o.status       = run_end_q ? status_q : ST_OK;
    end
  end

`include "nal_config_record_to_annexb_top_assert.svh"

  `NCR2AB_ASSERT(a_sc_has_payload,
    (sc_left_q == 3'd0) || (pay_valid_q && pay_present_q), "start code without payload byte")
  `NCR2AB_ASSERT(a_take_when_draining,
    !take || !busy || last_out, "record byte taken over pending output")
  `NCR2AB_ASSERT_NEXT(a_sc_countdown, out_valid && !out_stall && (sc_left_q != 3'd0),
    sc_left_q == $past(sc_left_q) - 3'd1, "start code count skipped")
  `NCR2AB_ASSERT(a_status_on_end,
    !out_valid || out_data_o.run_end || (out_data_o.status == ST_OK), "status outside run end")

endmodule
